### src/kad_pkg.sv
// Package: shared constants, codes and queue entry type for the KISS frame decoder.
`timescale 1ns / 1ps

package kad_pkg;

	localparam int KAD_MAX_MTU  = 256;
	localparam int QUEUE_DEPTH  = 4;
	localparam int PTR_W        = $clog2(QUEUE_DEPTH);
	localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);

	localparam int MAXLEN_W     = 9;
	localparam int MINLEN_W     = 8;
	localparam int PLEN_W       = 9;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 9;

	localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RST = 9'd256;
	localparam logic [MINLEN_W-1:0] MIN_LENGTH_RST = 8'd24;

	localparam logic [7:0] K_FEND  = 8'hC0;
	localparam logic [7:0] K_FESC  = 8'hDB;
	localparam logic [7:0] K_TFEND = 8'hDC;
	localparam logic [7:0] K_TFESC = 8'hDD;

	localparam int HDR_SKIP      = 16;
	localparam int PAYLOAD_START = 20;
	localparam int LEN_OVERHEAD  = 21;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 1'b1;

	typedef enum logic [2:0] {
		KIND_DISCARD  = 3'd0,
		KIND_ID       = 3'd1,
		KIND_PAYLOAD  = 3'd2,
		KIND_ACCEPT   = 3'd3,
		KIND_SHORT    = 3'd4,
		KIND_OVERFLOW = 3'd5
	} kad_kind_t;

	// One queued record: up to two results of one input byte.
	typedef struct packed {
		kad_kind_t         kind;
		logic              two;   // a discarded-byte result follows
		logic [7:0]        data;
		logic [31:0]       id;
		logic [PLEN_W-1:0] plen;
		logic [31:0]       good;
		logic [31:0]       err;
	} kad_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} kad_q_status_t;

endpackage

### src/kad_if.sv
// Interfaces: byte input channel and result output channel.
`timescale 1ns / 1ps

interface kad_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface kad_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  data_byte;
	logic [31:0] frame_id;
	logic [8:0]  payload_length;
	logic [31:0] good_frames;
	logic [31:0] error_frames;
	logic        last;

	modport source (output valid, output kind, output data_byte, output frame_id,
		output payload_length, output good_frames, output error_frames, output last,
		input ready);
	modport sink (input valid, input kind, input data_byte, input frame_id,
		input payload_length, input good_frames, input error_frames, input last,
		output ready);
endinterface

### src/kad_front.sv
// Front end: takes bytes, runs the KISS deframing state and builds queue records.
`timescale 1ns / 1ps

module kad_front import kad_pkg::*; #(
	parameter int MAX_MTU = KAD_MAX_MTU
) (
	input  logic                  clk,
	input  logic                  arst_n,
	kad_in_if.sink                byte_ch,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  kad_q_status_t         q_status,
	output logic                  push,
	output kad_entry_t            entry
);

	localparam int LEN_RAW = $clog2(MAX_MTU + 2);
	localparam int LEN_W   = (LEN_RAW > MAXLEN_W) ? LEN_RAW : MAXLEN_W;
	localparam logic [LEN_W-1:0] MTU_L   = LEN_W'(MAX_MTU);
	localparam logic [LEN_W-1:0] HDR_L   = LEN_W'(HDR_SKIP);
	localparam logic [LEN_W-1:0] PAY_L   = LEN_W'(PAYLOAD_START);
	localparam logic [LEN_W-1:0] LAST_ID = LEN_W'(PAYLOAD_START - 1);
	localparam logic [LEN_W-1:0] OVH_L   = LEN_W'(LEN_OVERHEAD);
	localparam logic [MINLEN_W-1:0] MIN_FLOOR = MINLEN_W'(LEN_OVERHEAD);

	typedef enum logic [2:0] {
		MODE_IDLE = 3'b001,
		MODE_OPEN = 3'b010,
		MODE_ESC  = 3'b100
	} kad_mode_t;

	logic [MAXLEN_W-1:0] max_length_q;
	logic [MINLEN_W-1:0] min_length_q;

	kad_mode_t         mode_q, mode_n, mode_eff;
	logic [LEN_W-1:0]  len_q, len_n, len_eff;
	logic              skip_q, skip_n;
	logic [31:0]       id_q, id_n;
	logic [7:0]        held_q, held_n;
	logic              hv_q, hv_n, hv_eff;
	logic [31:0]       good_q, good_n;
	logic [31:0]       err_q, err_n;

	logic [LEN_W-1:0]    limit, max_ext;
	logic [MINLEN_W-1:0] minl;
	logic                ovf;
	logic                store_en;
	logic [7:0]          store_val;
	logic                emit;
	logic                accept;
	logic [7:0]          b;

	assign b       = byte_ch.rx_byte;
	assign max_ext = LEN_W'(max_length_q);
	assign limit   = (max_ext < MTU_L) ? max_ext : MTU_L;
	assign minl    = (min_length_q < MIN_FLOOR) ? MIN_FLOOR : min_length_q;
	assign ovf     = (mode_q != MODE_IDLE) && (len_q > limit);

	assign byte_ch.ready = !q_status.full;
	assign accept        = byte_ch.valid && byte_ch.ready;
	assign push          = accept && emit;

	always_comb begin
		mode_eff  = ovf ? MODE_IDLE : mode_q;
		len_eff   = ovf ? '0 : len_q;
		hv_eff    = ovf ? 1'b0 : hv_q;
		mode_n    = mode_eff;
		len_n     = len_eff;
		skip_n    = skip_q;
		id_n      = id_q;
		held_n    = ovf ? 8'h00 : held_q;
		hv_n      = hv_eff;
		good_n    = good_q;
		err_n     = ovf ? err_q + 32'd1 : err_q;
		store_en  = 1'b0;
		store_val = b;
		emit      = ovf;
		entry     = '0;
		entry.kind = KIND_OVERFLOW;

		unique case (mode_eff)
			MODE_IDLE: begin
				if (b != K_FEND) begin
					emit       = 1'b1;
					entry.two  = ovf;
					entry.kind = ovf ? KIND_OVERFLOW : KIND_DISCARD;
					entry.data = b;
				end else begin
					mode_n = MODE_OPEN;
					len_n  = '0;
					skip_n = 1'b1;
					id_n   = '0;
					hv_n   = 1'b0;
					held_n = 8'h00;
				end
			end
			MODE_ESC: begin
				mode_n = MODE_OPEN;
				if (b == K_TFESC) begin
					store_en  = 1'b1;
					store_val = K_FESC;
				end else if (b == K_TFEND) begin
					store_en  = 1'b1;
					store_val = K_FEND;
				end
			end
			MODE_OPEN: begin
				if (b == K_FESC) begin
					mode_n = MODE_ESC;
				end else if (b == K_FEND) begin
					if (len_eff != '0) begin
						emit = 1'b1;
						if (len_eff < LEN_W'(minl)) begin
							err_n      = err_q + 32'd1;
							entry.kind = KIND_SHORT;
						end else begin
							good_n     = good_q + 32'd1;
							entry.kind = KIND_ACCEPT;
							entry.plen = PLEN_W'(len_eff - OVH_L);
						end
						mode_n = MODE_IDLE;
						len_n  = '0;
						hv_n   = 1'b0;
						held_n = 8'h00;
					end
				end else if (skip_q) begin
					skip_n = 1'b0;
				end else begin
					store_en = 1'b1;
				end
			end
			default: begin
				mode_n = MODE_IDLE;
			end
		endcase

		if (store_en) begin
			if (len_eff >= HDR_L && len_eff < PAY_L) begin
				id_n = {id_q[23:0], store_val};
				if (len_eff == LAST_ID) begin
					emit       = 1'b1;
					entry.kind = KIND_ID;
					entry.id   = id_n;
				end
			end else if (len_eff >= PAY_L) begin
				if (hv_eff) begin
					emit       = 1'b1;
					entry.kind = KIND_PAYLOAD;
					entry.data = held_q;
				end
				held_n = store_val;
				hv_n   = 1'b1;
			end
			len_n = len_eff + LEN_W'(1);
		end

		entry.good = good_n;
		entry.err  = err_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RST;
			min_length_q <= MIN_LENGTH_RST;
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_MAX_LENGTH) begin
				max_length_q <= cfg_wdata;
			end else if (cfg_index == REG_MIN_LENGTH) begin
				min_length_q <= cfg_wdata[MINLEN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			len_q  <= '0;
			skip_q <= 1'b0;
			id_q   <= '0;
			held_q <= '0;
			hv_q   <= 1'b0;
			good_q <= '0;
			err_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_n;
			len_q  <= len_n;
			skip_q <= skip_n;
			id_q   <= id_n;
			held_q <= held_n;
			hv_q   <= hv_n;
			good_q <= good_n;
			err_q  <= err_n;
		end
	end

endmodule

### src/kad_fifo.sv
// Record queue between the front end and the output sequencer.
`timescale 1ns / 1ps

module kad_fifo import kad_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  kad_entry_t    wr_entry,
	input  logic          pop,
	output kad_q_status_t status,
	output kad_entry_t    head
);

	kad_entry_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### src/kad_back.sv
// Output sequencer: drives the result channel from queued records.
`timescale 1ns / 1ps

module kad_back import kad_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  kad_q_status_t q_status,
	input  kad_entry_t    head,
	output logic          pop,
	kad_out_if.source     result_ch
);

	logic phase_q;   // second result of a two-result record
	logic xfer;

	assign result_ch.valid = !q_status.empty;
	assign xfer            = result_ch.valid && result_ch.ready;
	assign pop             = xfer && (!head.two || phase_q);

	assign result_ch.kind           = phase_q ? KIND_DISCARD : head.kind;
	assign result_ch.data_byte      = (phase_q || head.kind != KIND_OVERFLOW) ?
		head.data : 8'h00;
	assign result_ch.frame_id       = head.id;
	assign result_ch.payload_length = head.plen;
	assign result_ch.good_frames    = head.good;
	assign result_ch.error_frames   = head.err;
	assign result_ch.last           = !head.two || phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (xfer) begin
			phase_q <= head.two && !phase_q;
		end
	end

endmodule

### src/kiss_ax25_frame_decoder_top.sv
// KISS / AX.25 frame decoder: one received serial byte in, decoded results out.
//
// byte_ch carries one serial byte per transfer (valid/ready). result_ch gives
// the results each byte causes: discarded bytes outside a frame, the 32-bit
// frame identifier, payload bytes (one byte late), frame accept with payload
// length, short-frame and overflow errors, plus running good/error counts.
// last marks the final result of a byte; bytes with no result give nothing.
// cfg_wr_en/cfg_index/cfg_wdata write max_length (0) and min_length (1);
// write only while the block is idle.
// A result is offered from the record queue once its byte's record is in it.
// Throughput: one byte per cycle in while the queue is not full, one result per
// cycle out while ready is high; a discarded byte ending an overflow gives two results.
// The front end and the output side are parted by a four-record queue, so
// byte_ch keeps flowing while result_ch stalls until the queue fills; then
// byte_ch.ready drops.
// Reset clears the frame state, the counters and the queue, and restores the
// registers to 256 and 24.
`timescale 1ns / 1ps

module kiss_ax25_frame_decoder_top import kad_pkg::*; #(
	parameter int MAX_MTU = KAD_MAX_MTU
) (
	input  logic                  clk,
	input  logic                  arst_n,
	kad_in_if.sink                byte_ch,
	kad_out_if.source             result_ch,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	kad_q_status_t q_status;
	kad_entry_t    wr_entry;
	kad_entry_t    head;
	logic          push;
	logic          pop;

	kad_front #(
		.MAX_MTU (MAX_MTU)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_status  (q_status),
		.push      (push),
		.entry     (wr_entry)
	);

	kad_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.status   (q_status),
		.head     (head)
	);

	kad_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.head      (head),
		.pop       (pop),
		.result_ch (result_ch)
	);

endmodule

### tb/kad_checker.sv
// Checker: watches the byte and result channels, predicts the decoder output and compares.
`timescale 1ns / 1ps

module kad_checker import kad_pkg::*; #(
	parameter int MAX_MTU = KAD_MAX_MTU
) (
	input  logic                  clk,
	input  logic                  arst_n,
	kad_in_if                     byte_mon,
	kad_out_if                    result_mon,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    mismatches,
	output int                    outstanding
);

	typedef enum logic [1:0] {
		FRM_IDLE,
		FRM_OPEN,
		FRM_ESC
	} frame_mode_t;

	typedef struct packed {
		kad_kind_t         kind;
		logic [7:0]        data;
		logic [31:0]       id;
		logic [PLEN_W-1:0] plen;
		logic [31:0]       good;
		logic [31:0]       err;
		logic              last;
	} decoded_t;

	decoded_t decoded_q[$];
	decoded_t byte_results[$];

	logic [MAXLEN_W-1:0] max_len;
	logic [MINLEN_W-1:0] min_len;

	frame_mode_t frm_mode;
	int          stored_len;
	logic        skip_cmd;
	logic [31:0] id_shift;
	logic [7:0]  held_byte;
	logic        held_valid;
	logic [31:0] good_cnt;
	logic [31:0] err_cnt;

	function automatic void add_result(input kad_kind_t kind, input logic [7:0] data,
		input logic [31:0] id, input logic [PLEN_W-1:0] plen);
		decoded_t r;
		r.kind = kind;
		r.data = data;
		r.id   = id;
		r.plen = plen;
		r.good = good_cnt;
		r.err  = err_cnt;
		r.last = 1'b0;
		byte_results.push_back(r);
	endfunction

	function automatic void close_frame();
		frm_mode   = FRM_IDLE;
		stored_len = 0;
		held_valid = 1'b0;
		held_byte  = 8'h00;
	endfunction

	function automatic void store_byte(input logic [7:0] b);
		if (stored_len >= HDR_SKIP && stored_len < PAYLOAD_START) begin
			id_shift = {id_shift[23:0], b};
			if (stored_len == PAYLOAD_START - 1)
				add_result(KIND_ID, 8'h00, id_shift, '0);
		end else if (stored_len >= PAYLOAD_START) begin
			// payload goes out one stored byte late
			if (held_valid)
				add_result(KIND_PAYLOAD, held_byte, 32'h0, '0);
			held_byte  = b;
			held_valid = 1'b1;
		end
		if (stored_len < 24'hFFFFFF)
			stored_len++;
	endfunction

	function automatic void decode_rx_byte(input logic [7:0] b);
		int       lim;
		int       minl;
		decoded_t r;
		lim  = (int'(max_len) < MAX_MTU) ? int'(max_len) : MAX_MTU;
		minl = (int'(min_len) < LEN_OVERHEAD) ? LEN_OVERHEAD : int'(min_len);
		byte_results.delete();
		if (frm_mode != FRM_IDLE && stored_len > lim) begin
			err_cnt++;
			close_frame();
			add_result(KIND_OVERFLOW, 8'h00, 32'h0, '0);
		end
		case (frm_mode)
			FRM_IDLE: begin
				if (b != K_FEND) begin
					add_result(KIND_DISCARD, b, 32'h0, '0);
				end else begin
					frm_mode   = FRM_OPEN;
					stored_len = 0;
					skip_cmd   = 1'b1;
					id_shift   = 32'h0;
					held_valid = 1'b0;
					held_byte  = 8'h00;
				end
			end
			FRM_ESC: begin
				if (b == K_TFESC)
					store_byte(K_FESC);
				else if (b == K_TFEND)
					store_byte(K_FEND);
				frm_mode = FRM_OPEN;
			end
			default: begin
				if (b == K_FESC) begin
					frm_mode = FRM_ESC;
				end else if (b == K_FEND) begin
					// an empty frame end leaves the frame open
					if (stored_len > 0) begin
						if (stored_len < minl) begin
							err_cnt++;
							add_result(KIND_SHORT, 8'h00, 32'h0, '0);
						end else begin
							good_cnt++;
							add_result(KIND_ACCEPT, 8'h00, 32'h0,
								PLEN_W'(stored_len - LEN_OVERHEAD));
						end
						close_frame();
					end
				end else if (skip_cmd) begin
					skip_cmd = 1'b0;
				end else begin
					store_byte(b);
				end
			end
		endcase
		foreach (byte_results[i]) begin
			r = byte_results[i];
			r.last = (i == byte_results.size() - 1);
			decoded_q.push_back(r);
		end
	endfunction

	task automatic check_field(input string name, input logic [31:0] want_v,
		input logic [31:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		decoded_t want;
		if (!arst_n) begin
			decoded_q.delete();
			max_len     = MAX_LENGTH_RST;
			min_len     = MIN_LENGTH_RST;
			frm_mode    = FRM_IDLE;
			stored_len  = 0;
			skip_cmd    = 1'b0;
			id_shift    = 32'h0;
			held_byte   = 8'h00;
			held_valid  = 1'b0;
			good_cnt    = 32'h0;
			err_cnt     = 32'h0;
			mismatches  = 0;
			outstanding <= 0;
		end else begin
			// results never come out in the same cycle as their byte, so retire first
			if (result_mon.valid && result_mon.ready) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: result kind %0d with nothing expected", $time,
						result_mon.kind);
					mismatches++;
				end else begin
					want = decoded_q.pop_front();
					check_field("kind", 32'(want.kind), 32'(result_mon.kind));
					check_field("data_byte", 32'(want.data), 32'(result_mon.data_byte));
					check_field("frame_id", want.id, result_mon.frame_id);
					check_field("payload_length", 32'(want.plen),
						32'(result_mon.payload_length));
					check_field("good_frames", want.good, result_mon.good_frames);
					check_field("error_frames", want.err, result_mon.error_frames);
					check_field("last", 32'(want.last), 32'(result_mon.last));
				end
			end
			if (byte_mon.valid && byte_mon.ready)
				decode_rx_byte(byte_mon.rx_byte);
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_MAX_LENGTH: max_len = cfg_wdata[MAXLEN_W-1:0];
					REG_MIN_LENGTH: min_len = cfg_wdata[MINLEN_W-1:0];
					default: ;
				endcase
			end
			outstanding <= decoded_q.size();
		end
	end

endmodule

### tb/tb.sv
// Testbench top: clock, reset, byte stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
	import kad_pkg::*;

	localparam int PHASE_BYTES     = 410;
	localparam int SETTLE_CYCLES   = 8;
	localparam int END_CYCLES      = 20;
	localparam int HOLD_OFF_CYCLES = 120;
	localparam int WATCHDOG_LIMIT  = 3000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int   mismatches;
	int   outstanding;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   bytes_sent;
	int   frame_limit;
	int   quiet_cycles;
	logic hold_off_req;
	logic hold_off_taken;

	kad_in_if  byte_ch ();
	kad_out_if result_ch ();

	kiss_ax25_frame_decoder_top #(
		.MAX_MTU(KAD_MAX_MTU)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.result_ch (result_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	kad_checker #(
		.MAX_MTU(KAD_MAX_MTU)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_mon    (byte_ch),
		.result_mon  (result_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver side: random stalls, plus one long hold-off on request
	initial begin
		result_ch.ready <= 1'b0;
		hold_off_taken = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req && !hold_off_taken) begin
				hold_off_taken = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid   <= 1'b1;
		byte_ch.rx_byte <= b;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_escaped(input logic [7:0] b);
		if (b == K_FEND) begin
			send_byte(K_FESC);
			send_byte(K_TFEND);
		end else if (b == K_FESC) begin
			send_byte(K_FESC);
			send_byte(K_TFESC);
		end else begin
			send_byte(b);
		end
	endtask

	// stop offering and wait until every expected result has come out
	task automatic drain_results();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_MAX_LENGTH)
			frame_limit = ((val & 'h1FF) < KAD_MAX_MTU) ? (val & 'h1FF) : KAD_MAX_MTU;
	endtask

	task automatic send_frame(input int n);
		logic [7:0] cmd;
		logic [7:0] b;
		send_byte(K_FEND);
		// escaped byte ahead of the command byte
		if ($urandom_range(19) == 0) begin
			send_byte(K_FESC);
			send_byte(K_TFESC);
		end
		cmd = 8'($urandom);
		if (cmd == K_FEND || cmd == K_FESC)
			cmd = 8'h00;
		send_byte(cmd);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(24) == 0) begin
				send_byte(K_FESC);
				case ($urandom_range(2))
					0: send_byte(K_FEND);
					1: send_byte(K_FESC);
					default: send_byte(8'($urandom));
				endcase
			end
			if ($urandom_range(6) == 0) begin
				case ($urandom_range(3))
					0: b = K_FEND;
					1: b = K_FESC;
					2: b = K_TFEND;
					default: b = K_TFESC;
				endcase
			end else begin
				b = 8'($urandom);
			end
			send_escaped(b);
		end
		// now and then the closing frame end is left out
		if ($urandom_range(15) != 0)
			send_byte(K_FEND);
	endtask

	task automatic random_traffic(input int target);
		int r;
		int n;
		bytes_sent = 0;
		while (bytes_sent < target) begin
			if ($urandom_range(9) < 3)
				repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
			r = $urandom_range(99);
			if (r < 8)
				n = $urandom_range(frame_limit + 3, frame_limit - 3);
			else if (r < 22)
				n = $urandom_range(19, 0);
			else
				n = $urandom_range(48, 19);
			send_frame(n);
		end
	endtask

	initial begin
		logic [7:0] directed_q[$];

		arst_n          <= 1'b0;
		byte_ch.valid   <= 1'b0;
		byte_ch.rx_byte <= 8'h00;
		cfg_wr_en       <= 1'b0;
		cfg_index       <= '0;
		cfg_wdata       <= '0;
		hold_off_req    <= 1'b0;
		recv_idle_pct   <= 68;
		send_idle_pct   = 11;
		frame_limit     = KAD_MAX_MTU;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		drain_results();

		// low settings: limit 24, minimum 21
		write_reg(REG_MAX_LENGTH, 24);
		write_reg(REG_MIN_LENGTH, 21);
		// discards, empty frame end, escape before the command byte, frame end
		// after an escape, escapes inside the identifier and payload, an accepted
		// frame and then a short one
		directed_q = '{8'h00, K_FESC,
			K_FEND, K_FEND, K_FESC, K_TFEND, 8'h5A, K_FESC, K_FEND,
			8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
			8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F,
			8'h80, K_FESC, K_TFESC, 8'h00, 8'h7F,
			8'hFF, K_FESC, K_TFEND, 8'h01, K_FEND,
			K_FEND, 8'h33, 8'h44, K_FEND};
		foreach (directed_q[i])
			send_byte(directed_q[i]);
		random_traffic(PHASE_BYTES);
		drain_results();

		send_idle_pct = 68;
		recv_idle_pct <= 11;
		write_reg(REG_MAX_LENGTH, 256);
		write_reg(REG_MIN_LENGTH, 255);
		random_traffic(PHASE_BYTES);
		drain_results();

		// limit above the MTU and minimum below the frame overhead
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		write_reg(REG_MAX_LENGTH, 300);
		write_reg(REG_MIN_LENGTH, 10);
		hold_off_req <= 1'b1;
		random_traffic(PHASE_BYTES);
		drain_results();

		write_reg(REG_MAX_LENGTH, 100);
		write_reg(REG_MIN_LENGTH, 60);
		random_traffic(PHASE_BYTES);
		drain_results();

		repeat (END_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
